// File: rtl/pbmmh_pkg.sv
// Shared widths, action codes and controller states for the per-bin median peak hold.
package pbmmh_pkg;

   localparam int BIN_W = 10;
   localparam int VAL_W = 32;
   localparam int NB_W  = 5;

   // Request action codes
   localparam logic ACT_PUSH  = 1'b0;
   localparam logic ACT_WRITE = 1'b1;

   // Controller states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MED_LO,
      ST_MED_HI,
      ST_EMIT
   } state_type;

endpackage

// File: rtl/pbmmh_if.sv
// Valid/ready channel interfaces for request, response and control register beats.
interface pbmmh_req_if;
   import pbmmh_pkg::*;

   logic             valid;
   logic             ready;
   logic             action;
   logic [BIN_W-1:0] bin_id;
   logic [VAL_W-1:0] power_value;

   modport source (output valid, action, bin_id, power_value, input ready);
   modport sink   (input valid, action, bin_id, power_value, output ready);
endinterface

interface pbmmh_rsp_if;
   import pbmmh_pkg::*;

   logic             valid;
   logic             ready;
   logic [BIN_W-1:0] out_bin;
   logic [VAL_W-1:0] held_value;
   logic             raised;

   modport source (output valid, out_bin, held_value, raised, input ready);
   modport sink   (input valid, out_bin, held_value, raised, output ready);
endinterface

interface pbmmh_csr_if;
   import pbmmh_pkg::*;

   logic            valid;
   logic            ready;
   logic [NB_W-1:0] num_blocks;

   modport source (output valid, num_blocks, input ready);
   modport sink   (input valid, num_blocks, output ready);
endinterface

// File: rtl/per_bin_median_max_hold.sv
// Per-bin running median with peak hold: sorted sample cells plus a held-median memory.
//
//  channel   dir  beat contents
//  req_bus   in   action, bin_id, power_value
//  rsp_bus   out  out_bin, held_value, raised
//  csr_bus   in   num_blocks
//
// A push that does not complete a collection, a direct write and an ignored bin are
// taken in the idle state. A completing push steps through accept and memory read,
// reads of the lower and upper middle sample cells, and emit; the emit step waits
// while the response register still holds an untaken beat. After reset a clearing pass
// zeroes the held memory, one entry a cycle, over every bin; no request is taken until then.
module per_bin_median_max_hold #(
   parameter int MAX_BLOCKS    = 16,
   parameter int SPECTRUM_BINS = 1024
) (
   input  logic        clock,
   input  logic        reset,
   pbmmh_req_if.sink   req_bus,
   pbmmh_rsp_if.source rsp_bus,
   pbmmh_csr_if.sink   csr_bus
);
   import pbmmh_pkg::*;

   localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
   localparam int IW    = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int AW    = (SPECTRUM_BINS > 1) ? $clog2(SPECTRUM_BINS) : 1;

   // Control and configuration state
   state_type         state_ff, state_in;
   logic [NB_W-1:0]   num_blocks_ff;
   logic [AW-1:0]     clr_cnt_ff;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [CNT_W-1:0]  count_ff;
   logic [BIN_W-1:0]  coll_bin_ff;

   // Sorted sample cells and median datapath
   logic [VAL_W-1:0]  cells_ff [MAX_BLOCKS];
   logic [VAL_W-1:0]  cells_in [MAX_BLOCKS];
   logic [MAX_BLOCKS-1:0] gt;
   logic [VAL_W-1:0]  lo_ff;
   logic [VAL_W-1:0]  med_ff;
   logic [VAL_W-1:0]  cell_sel;
   logic [CNT_W-1:0]  sel_pos;
   logic [VAL_W:0]    med_sum;

   // Held-median memory
   logic [VAL_W-1:0]  held_mem [SPECTRUM_BINS];
   logic [VAL_W-1:0]  rd_data_ff;
   logic              mem_re, mem_we;
   logic [AW-1:0]     mem_waddr;
   logic [VAL_W-1:0]  mem_wdata;

   // Response register
   logic              rsp_valid_ff;
   logic [BIN_W-1:0]  rsp_bin_ff;
   logic [VAL_W-1:0]  rsp_held_ff;
   logic              rsp_raised_ff;

   // Request decode
   logic              req_fire, bin_ok, push_fire, write_fire;
   logic              restart, complete, rsp_free, rsp_load, raise;
   logic [CNT_W-1:0]  eff_fill, new_fill, target;
   logic [AW-1:0]     req_addr, coll_addr;
   logic [BIN_W+AW-1:0] req_addr_wide, coll_addr_wide;
   logic              req_ready;

   assign req_fire   = req_bus.valid && req_ready;
   assign bin_ok     = (req_bus.bin_id != '0) &&
                       ({22'd0, req_bus.bin_id} < 32'(SPECTRUM_BINS));
   assign push_fire  = req_fire && bin_ok && (req_bus.action == ACT_PUSH);
   assign write_fire = req_fire && bin_ok && (req_bus.action == ACT_WRITE);

   assign req_addr_wide  = {{AW{1'b0}}, req_bus.bin_id};
   assign coll_addr_wide = {{AW{1'b0}}, coll_bin_ff};
   assign req_addr       = req_addr_wide[AW-1:0];
   assign coll_addr      = coll_addr_wide[AW-1:0];

   // Clamp the block count to 1..MAX_BLOCKS
   always_comb begin
      if (num_blocks_ff == '0) begin
         target = CNT_W'(1);
      end else if ({27'd0, num_blocks_ff} > 32'(MAX_BLOCKS)) begin
         target = CNT_W'(MAX_BLOCKS);
      end else begin
         target = CNT_W'(num_blocks_ff);
      end
   end

   // Restart collection on a new bin or after a completed one
   assign restart  = (fill_ff == '0) || (req_bus.bin_id != coll_bin_ff);
   assign eff_fill = restart ? '0 : fill_ff;
   assign new_fill = eff_fill + CNT_W'(1);
   assign complete = (new_fill >= target);

   // Compare-and-shift insertion: every cell above the new value moves up one place
   always_comb begin
      for (int i = 0; i < MAX_BLOCKS; i++) begin
         gt[i] = (CNT_W'(i) < eff_fill) && (cells_ff[i] > req_bus.power_value);
      end
      for (int i = 0; i < MAX_BLOCKS; i++) begin
         if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
            cells_in[i] = cells_ff[(i > 0) ? i - 1 : 0];
         end else if (gt[i] || CNT_W'(i) == eff_fill) begin
            cells_in[i] = req_bus.power_value;
         end else begin
            cells_in[i] = cells_ff[i];
         end
      end
   end

   // Pick the lower middle cell first, then the upper one
   assign sel_pos  = (state_ff == ST_MED_LO) ? ((count_ff - CNT_W'(1)) >> 1) : (count_ff >> 1);
   assign cell_sel = cells_ff[sel_pos[IW-1:0]];
   assign med_sum  = {1'b0, lo_ff} + {1'b0, cell_sel};

   assign rsp_free = !rsp_valid_ff || rsp_bus.ready;
   assign raise    = med_ff > rd_data_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_cnt_ff == AW'(SPECTRUM_BINS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (push_fire && complete) state_in = ST_MED_LO;
         end
         ST_MED_LO: state_in = ST_MED_HI;
         ST_MED_HI: state_in = ST_EMIT;
         ST_EMIT: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // Outputs of the controller
   always_comb begin
      req_ready = 1'b0;
      mem_re    = 1'b0;
      mem_we    = 1'b0;
      mem_waddr = clr_cnt_ff;
      mem_wdata = '0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            mem_re    = push_fire;
            mem_we    = write_fire;
            mem_waddr = req_addr;
            mem_wdata = req_bus.power_value;
         end
         ST_MED_LO, ST_MED_HI: begin
         end
         ST_EMIT: begin
            rsp_load  = rsp_free;
            mem_we    = rsp_free && raise;
            mem_waddr = coll_addr;
            mem_wdata = med_ff;
         end
         default: begin
         end
      endcase
   end

   // Fill count for the collection in progress
   always_comb begin
      fill_in = fill_ff;
      if (push_fire) fill_in = complete ? '0 : new_fill;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         num_blocks_ff <= NB_W'(1);
         clr_cnt_ff    <= '0;
         fill_ff       <= '0;
         coll_bin_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         if (csr_bus.valid) num_blocks_ff <= csr_bus.num_blocks;
         if (state_ff == ST_CLEAR) clr_cnt_ff <= clr_cnt_ff + AW'(1);
         if (push_fire) coll_bin_ff <= req_bus.bin_id;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers: cells, median operands, response beat
   always_ff @(posedge clock) begin
      if (push_fire) begin
         cells_ff <= cells_in;
         if (complete) count_ff <= new_fill;
      end
      if (state_ff == ST_MED_LO) lo_ff  <= cell_sel;
      if (state_ff == ST_MED_HI) med_ff <= med_sum[VAL_W:1];
      if (rsp_load) begin
         rsp_bin_ff    <= coll_bin_ff;
         rsp_held_ff   <= raise ? med_ff : rd_data_ff;
         rsp_raised_ff <= raise;
      end
   end

   // Held-median memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) held_mem[mem_waddr] <= mem_wdata;
   end

   always_ff @(posedge clock) begin
      if (mem_re) rd_data_ff <= held_mem[req_addr];
   end

   // Drive the channels
   assign req_bus.ready      = req_ready;
   assign csr_bus.ready      = 1'b1;
   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.out_bin    = rsp_bin_ff;
   assign rsp_bus.held_value = rsp_held_ff;
   assign rsp_bus.raised     = rsp_raised_ff;

   // A collection never holds a full set between pushes
   assert property (@(posedge clock) disable iff (reset)
      {{(32 - CNT_W){1'b0}}, fill_ff} < 32'(MAX_BLOCKS))
      else $error("fill count reached the block limit between pushes");

   // A response beat is raised only from the emit step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EMIT))
      else $error("response raised outside emit");

   // Median reads start only from a completing push
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MED_LO) |-> $past(push_fire))
      else $error("median read without a completing push");

   // No request is taken during the clearing pass
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_fire)
      else $error("request taken while clearing held memory");

   // A raised beat never lowers the held value
   assert property (@(posedge clock) disable iff (reset)
      (rsp_load && raise) |=> (rsp_held_ff > $past(rd_data_ff)))
      else $error("raised beat does not exceed the old held value");

endmodule
